[src/gts_pkg.sv]
// ----------------------------------------------------------------------------
// gts_pkg
// Types, step codes and command codes shared by the grasp task sequencer.
// ----------------------------------------------------------------------------
package gts_pkg;

  localparam int unsigned AGE_W   = 20;
  localparam int unsigned WIDTH_W = 16;
  localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

  // steps
  localparam logic [3:0] S_IDLE          = 4'd0;
  localparam logic [3:0] S_PLANNING      = 4'd1;
  localparam logic [3:0] S_CHOSEN        = 4'd2;
  localparam logic [3:0] S_OPEN_JAW      = 4'd3;
  localparam logic [3:0] S_MOVE_STANDOFF = 4'd4;
  localparam logic [3:0] S_AT_STANDOFF   = 4'd5;
  localparam logic [3:0] S_MOVE_HANDLE   = 4'd6;
  localparam logic [3:0] S_AT_HANDLE     = 4'd7;
  localparam logic [3:0] S_CLOSE_JAW     = 4'd8;
  localparam logic [3:0] S_CHECK_GRASP   = 4'd9;
  localparam logic [3:0] S_HOLDING       = 4'd10;
  localparam logic [3:0] S_MOVE_BASE     = 4'd11;
  localparam logic [3:0] S_SUCCESS       = 4'd12;
  localparam logic [3:0] S_FAILED        = 4'd13;
  localparam logic [3:0] S_E_STOP        = 4'd14;

  // commands
  localparam logic [3:0] CMD_TICK     = 4'd0;
  localparam logic [3:0] CMD_STOP     = 4'd1;
  localparam logic [3:0] CMD_PLAN     = 4'd2;
  localparam logic [3:0] CMD_START    = 4'd3;
  localparam logic [3:0] CMD_ADVANCE  = 4'd4;
  localparam logic [3:0] CMD_CLOSE    = 4'd5;
  localparam logic [3:0] CMD_OPEN     = 4'd6;
  localparam logic [3:0] CMD_HOME     = 4'd7;
  localparam logic [3:0] CMD_PLAN_RES = 4'd8;

  // controller states
  localparam logic [2:0] CS_IDLE    = 3'd0;
  localparam logic [2:0] CS_REACHED = 3'd2;
  localparam logic [2:0] CS_STALLED = 3'd3;
  localparam logic [2:0] CS_PILLOW  = 3'd4;
  localparam logic [2:0] CS_ABORTED = 3'd5;

  // grip verdicts
  localparam logic [1:0] GRIP_HELD  = 2'd1;
  localparam logic [1:0] GRIP_EMPTY = 2'd2;

  // actions
  localparam logic [2:0] ACT_NONE     = 3'd0;
  localparam logic [2:0] ACT_STANDOFF = 3'd1;
  localparam logic [2:0] ACT_HANDLE   = 3'd2;
  localparam logic [2:0] ACT_CLOSE    = 3'd3;
  localparam logic [2:0] ACT_HOME     = 3'd4;

  // reject reasons
  localparam logic [2:0] REJ_NONE        = 3'd0;
  localparam logic [2:0] REJ_PLAN_BUSY   = 3'd1;
  localparam logic [2:0] REJ_NEED_PLAN   = 3'd2;
  localparam logic [2:0] REJ_NO_PLAN     = 3'd3;
  localparam logic [2:0] REJ_NEED_STANDOFF = 3'd4;
  localparam logic [2:0] REJ_EARLY_CLOSE = 3'd5;
  localparam logic [2:0] REJ_WAIT        = 3'd6;

  // fault reasons
  localparam logic [2:0] FLT_NONE        = 3'd0;
  localparam logic [2:0] FLT_SILENT      = 3'd1;
  localparam logic [2:0] FLT_LEG_MISSED  = 3'd2;
  localparam logic [2:0] FLT_ARM_STOPPED = 3'd3;
  localparam logic [2:0] FLT_JAW_OPEN    = 3'd4;
  localparam logic [2:0] FLT_JAW_SETTLE  = 3'd5;
  localparam logic [2:0] FLT_GRIP        = 3'd6;

  // configuration register indexes
  localparam logic [1:0] REG_SILENCE  = 2'd0;
  localparam logic [1:0] REG_JAW_TMO  = 2'd1;
  localparam logic [1:0] REG_JAW_TGT  = 2'd2;
  localparam logic [1:0] REG_JAW_TOL  = 2'd3;

  typedef struct packed {
    logic [AGE_W-1:0]   ctrl_silence_limit;
    logic [AGE_W-1:0]   jaw_timeout_limit;
    logic [WIDTH_W-1:0] jaw_open_target;
    logic [WIDTH_W-1:0] jaw_open_tolerance;
  } cfg_t;

  // classified word handed from front to back
  typedef struct packed {
    logic [3:0] command;
    logic       plan_ok;
    logic       arm_heard;
    logic       arm_moving;
    logic [2:0] ctrl_state;
    logic       silent;
    logic       jaw_opened;
    logic       verdict;
    logic       jaw_halted;
    logic       carrying;
    logic       auto_run;
  } cls_t;

  typedef struct packed {
    logic [3:0] step_code;
    logic [2:0] action;
    logic       accepted;
    logic [2:0] reject_reason;
    logic [2:0] fault_reason;
    logic       backout_kept;
  } res_t;

  function automatic logic step_busy(input logic [3:0] s);
    step_busy = (s == S_PLANNING) || (s == S_OPEN_JAW) || (s == S_MOVE_STANDOFF) ||
                (s == S_MOVE_HANDLE) || (s == S_CLOSE_JAW) || (s == S_CHECK_GRASP) ||
                (s == S_MOVE_BASE);
  endfunction

endpackage

[src/grasp_task_sequencer.sv]
// ----------------------------------------------------------------------------
// grasp_task_sequencer
// Fifteen-step pick sequencer for a gripper arm: front classifier, two-word
// queue, back end holding step, prior step and step age.
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  in       in_valid/in_ready     command, controller, jaw and grip status
//  out      out_valid/out_ready   step, action, accept/reject, fault, backout
//  cfg      cfg_valid/cfg_ready   cfg_index (2b), cfg_data (20b)
//
//  one word per cycle sustained while the output is not stalled; each word
//  passes a queue entry, then the output register, on its way to a result
//  the back end updates the step and the output register in the same cycle
//  synchronous active-low reset restores step idle and the register defaults
//  a stalled output holds the back end; the queue keeps in_ready up for up
//  to two more words
// ----------------------------------------------------------------------------
module grasp_task_sequencer #(
  parameter int unsigned SILENCE_RESET = 2000,
  parameter int unsigned JAW_TMO_RESET = 3000,
  parameter int unsigned JAW_TGT_RESET = 8000,
  parameter int unsigned JAW_TOL_RESET = 200
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_command,
  input  logic        in_arm_heard,
  input  logic        in_arm_moving,
  input  logic [2:0]  in_ctrl_state,
  input  logic [19:0] in_ctrl_age,
  input  logic        in_jaw_fresh,
  input  logic [15:0] in_jaw_width,
  input  logic        in_jaw_halted,
  input  logic [1:0]  in_grip,
  input  logic        in_carrying,
  input  logic        in_auto_run,
  input  logic        in_plan_ok,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_step_code,
  output logic [2:0]  out_action,
  output logic        out_accepted,
  output logic [2:0]  out_reject_reason,
  output logic [2:0]  out_fault_reason,
  output logic        out_backout_kept
);

  gts_pkg::cfg_t cfg_r, cfg_nxt;
  gts_pkg::cls_t q_din, q_dout;
  gts_pkg::res_t res;
  logic          q_push, q_full, q_pop, q_not_empty;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        gts_pkg::REG_SILENCE: cfg_nxt.ctrl_silence_limit = cfg_data;
        gts_pkg::REG_JAW_TMO: cfg_nxt.jaw_timeout_limit  = cfg_data;
        gts_pkg::REG_JAW_TGT: cfg_nxt.jaw_open_target    = cfg_data[15:0];
        gts_pkg::REG_JAW_TOL: cfg_nxt.jaw_open_tolerance = cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ctrl_silence_limit <= SILENCE_RESET[19:0];
      cfg_r.jaw_timeout_limit  <= JAW_TMO_RESET[19:0];
      cfg_r.jaw_open_target    <= JAW_TGT_RESET[15:0];
      cfg_r.jaw_open_tolerance <= JAW_TOL_RESET[15:0];
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  gts_front u_front (
    .cfg              (cfg_r),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_arm_heard     (in_arm_heard),
    .in_arm_moving    (in_arm_moving),
    .in_ctrl_state    (in_ctrl_state),
    .in_ctrl_age      (in_ctrl_age),
    .in_jaw_fresh     (in_jaw_fresh),
    .in_jaw_width     (in_jaw_width),
    .in_jaw_halted    (in_jaw_halted),
    .in_grip          (in_grip),
    .in_carrying      (in_carrying),
    .in_auto_run      (in_auto_run),
    .in_plan_ok       (in_plan_ok),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_din            (q_din)
  );

  gts_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .din       (q_din),
    .full      (q_full),
    .pop       (q_pop),
    .dout      (q_dout),
    .not_empty (q_not_empty)
  );

  gts_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_not_empty (q_not_empty),
    .q_dout      (q_dout),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .res         (res)
  );

  assign out_step_code     = res.step_code;
  assign out_action        = res.action;
  assign out_accepted      = res.accepted;
  assign out_reject_reason = res.reject_reason;
  assign out_fault_reason  = res.fault_reason;
  assign out_backout_kept  = res.backout_kept;

  a_acc_no_reason: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_accepted) |-> (out_reject_reason == gts_pkg::REJ_NONE))
    else $error("accepted word carries a reject reason");

  a_fault_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_fault_reason != gts_pkg::FLT_NONE)) |->
    ((out_step_code == gts_pkg::S_FAILED) || (out_step_code == gts_pkg::S_HOLDING)))
    else $error("fault reported outside failed or holding");

  a_backout_failed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_backout_kept) |-> (out_step_code == gts_pkg::S_FAILED))
    else $error("backout kept without failure");

  a_pop_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_valid)
    else $error("popped word did not reach the output");

endmodule

[src/gts_queue.sv]
// ----------------------------------------------------------------------------
// gts_queue
// Two-entry queue of classified words between front and back.
// ----------------------------------------------------------------------------
module gts_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  gts_pkg::cls_t din,
  output logic          full,
  input  logic          pop,
  output gts_pkg::cls_t dout,
  output logic          not_empty
);

  gts_pkg::cls_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign dout      = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

[src/gts_front.sv]
// ----------------------------------------------------------------------------
// gts_front
// Accepts input words and reduces the status fields to the flags the
// sequencer needs: controller silence, jaw opened, grip verdict.
// ----------------------------------------------------------------------------
module gts_front (
  input  gts_pkg::cfg_t          cfg,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [3:0]             in_command,
  input  logic                   in_arm_heard,
  input  logic                   in_arm_moving,
  input  logic [2:0]             in_ctrl_state,
  input  logic [gts_pkg::AGE_W-1:0]   in_ctrl_age,
  input  logic                   in_jaw_fresh,
  input  logic [gts_pkg::WIDTH_W-1:0] in_jaw_width,
  input  logic                   in_jaw_halted,
  input  logic [1:0]             in_grip,
  input  logic                   in_carrying,
  input  logic                   in_auto_run,
  input  logic                   in_plan_ok,
  input  logic                   q_full,
  output logic                   q_push,
  output gts_pkg::cls_t          q_din
);

  logic [gts_pkg::WIDTH_W-1:0] open_thr;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // threshold floors at zero
  assign open_thr = (cfg.jaw_open_target > cfg.jaw_open_tolerance) ?
                    (cfg.jaw_open_target - cfg.jaw_open_tolerance) : '0;

  always_comb begin
    q_din.command       = in_command;
    q_din.plan_ok       = in_plan_ok;
    q_din.arm_heard     = in_arm_heard;
    q_din.arm_moving    = in_arm_moving;
    q_din.ctrl_state    = in_ctrl_state;
    q_din.silent        = in_arm_heard && (in_ctrl_age > cfg.ctrl_silence_limit);
    q_din.jaw_opened    = in_jaw_fresh && (in_jaw_width >= open_thr);
    q_din.verdict       = (in_grip == gts_pkg::GRIP_HELD) || (in_grip == gts_pkg::GRIP_EMPTY);
    q_din.jaw_halted    = in_jaw_halted;
    q_din.carrying      = in_carrying;
    q_din.auto_run      = in_auto_run;
  end

endmodule

[src/gts_back.sv]
// ----------------------------------------------------------------------------
// gts_back
// Step register, step age and command handling; one word per cycle, while the
// output is not stalled, into a registered result.
// ----------------------------------------------------------------------------
module gts_back (
  input  logic          clk,
  input  logic          rst_n,
  input  gts_pkg::cfg_t cfg,
  input  logic          q_not_empty,
  input  gts_pkg::cls_t q_dout,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output gts_pkg::res_t res
);

  logic [3:0]                step_r, step_nxt;
  logic [3:0]                prior_r, prior_nxt;
  logic [gts_pkg::AGE_W-1:0] age_r, age_nxt, age_inc;
  logic                      out_valid_r;
  gts_pkg::res_t             res_r, res_nxt;
  logic                      leg_broken, leg_reached;
  logic [2:0]                leg_fault;
  logic                      jaw_tmo, s_busy;
  gts_pkg::cls_t             w;

  assign w         = q_dout;
  assign q_pop     = q_not_empty && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign res       = res_r;
  assign s_busy    = gts_pkg::step_busy(step_r);

  assign age_inc = (age_r == gts_pkg::AGE_MAX) ? age_r : age_r + 1'b1;
  assign jaw_tmo = age_inc > cfg.jaw_timeout_limit;

  // leg watch
  always_comb begin
    leg_broken  = 1'b0;
    leg_reached = 1'b0;
    leg_fault   = gts_pkg::FLT_NONE;
    if (w.silent) begin
      leg_broken = 1'b1;
      leg_fault  = gts_pkg::FLT_SILENT;
    end else if (!w.arm_heard || !w.arm_moving) begin
      if (age_inc > cfg.ctrl_silence_limit) begin
        leg_broken = 1'b1;
        leg_fault  = gts_pkg::FLT_LEG_MISSED;
      end
    end else if ((w.ctrl_state == gts_pkg::CS_IDLE) ||
                 (w.ctrl_state == gts_pkg::CS_STALLED) ||
                 (w.ctrl_state == gts_pkg::CS_PILLOW) ||
                 (w.ctrl_state == gts_pkg::CS_ABORTED)) begin
      leg_broken = 1'b1;
      leg_fault  = gts_pkg::FLT_ARM_STOPPED;
    end else begin
      leg_reached = (w.ctrl_state == gts_pkg::CS_REACHED);
    end
  end

  always_comb begin
    step_nxt  = step_r;
    prior_nxt = prior_r;
    age_nxt   = age_r;
    res_nxt   = '0;
    res_nxt.accepted = 1'b1;
    case (w.command)
      gts_pkg::CMD_TICK: begin
        age_nxt = age_inc;
        case (step_r)
          gts_pkg::S_OPEN_JAW: begin
            if (w.jaw_opened) begin
              step_nxt       = gts_pkg::S_MOVE_STANDOFF;
              res_nxt.action = gts_pkg::ACT_STANDOFF;
            end else if (jaw_tmo) begin
              step_nxt             = gts_pkg::S_FAILED;
              res_nxt.fault_reason = gts_pkg::FLT_JAW_OPEN;
            end
          end
          gts_pkg::S_MOVE_STANDOFF, gts_pkg::S_MOVE_HANDLE, gts_pkg::S_MOVE_BASE: begin
            if (leg_broken) begin
              step_nxt             = gts_pkg::S_FAILED;
              res_nxt.fault_reason = leg_fault;
              res_nxt.backout_kept = (step_r != gts_pkg::S_MOVE_BASE);
            end else if (leg_reached) begin
              if (step_r == gts_pkg::S_MOVE_STANDOFF) begin
                step_nxt = gts_pkg::S_AT_STANDOFF;
              end else if (step_r == gts_pkg::S_MOVE_HANDLE) begin
                step_nxt = gts_pkg::S_AT_HANDLE;
              end else begin
                step_nxt = w.carrying ? gts_pkg::S_SUCCESS : gts_pkg::S_IDLE;
              end
            end
          end
          gts_pkg::S_AT_STANDOFF: begin
            if (w.auto_run) begin
              step_nxt       = gts_pkg::S_MOVE_HANDLE;
              res_nxt.action = gts_pkg::ACT_HANDLE;
            end
          end
          gts_pkg::S_AT_HANDLE: begin
            if (w.auto_run) begin
              step_nxt       = gts_pkg::S_CLOSE_JAW;
              res_nxt.action = gts_pkg::ACT_CLOSE;
            end
          end
          gts_pkg::S_CLOSE_JAW: begin
            if (w.verdict || w.jaw_halted) begin
              step_nxt = gts_pkg::S_CHECK_GRASP;
            end else if (jaw_tmo) begin
              step_nxt             = gts_pkg::S_HOLDING;
              res_nxt.fault_reason = gts_pkg::FLT_JAW_SETTLE;
            end
          end
          gts_pkg::S_CHECK_GRASP: begin
            if (w.verdict) begin
              step_nxt = gts_pkg::S_HOLDING;
            end else if (jaw_tmo) begin
              step_nxt             = gts_pkg::S_HOLDING;
              res_nxt.fault_reason = gts_pkg::FLT_GRIP;
            end
          end
          gts_pkg::S_HOLDING: begin
            if (w.auto_run) begin
              step_nxt       = gts_pkg::S_MOVE_BASE;
              res_nxt.action = gts_pkg::ACT_HOME;
            end
          end
          default: begin
          end
        endcase
      end
      gts_pkg::CMD_STOP: begin
        step_nxt = gts_pkg::S_E_STOP;
      end
      gts_pkg::CMD_PLAN: begin
        if ((step_r == gts_pkg::S_IDLE) || (step_r == gts_pkg::S_CHOSEN) ||
            (step_r == gts_pkg::S_SUCCESS) || (step_r == gts_pkg::S_FAILED) ||
            (step_r == gts_pkg::S_E_STOP)) begin
          prior_nxt = step_r;
          step_nxt  = gts_pkg::S_PLANNING;
        end else begin
          res_nxt.accepted      = 1'b0;
          res_nxt.reject_reason = gts_pkg::REJ_PLAN_BUSY;
        end
      end
      gts_pkg::CMD_START: begin
        if (step_r == gts_pkg::S_CHOSEN) begin
          step_nxt = gts_pkg::S_OPEN_JAW;
        end else begin
          res_nxt.accepted      = 1'b0;
          res_nxt.reject_reason = (s_busy || (step_r == gts_pkg::S_AT_STANDOFF) ||
                                   (step_r == gts_pkg::S_AT_HANDLE) ||
                                   (step_r == gts_pkg::S_HOLDING)) ?
                                  gts_pkg::REJ_NEED_PLAN : gts_pkg::REJ_NO_PLAN;
        end
      end
      gts_pkg::CMD_ADVANCE: begin
        if (step_r == gts_pkg::S_AT_STANDOFF) begin
          step_nxt = gts_pkg::S_MOVE_HANDLE;
        end else begin
          res_nxt.accepted      = 1'b0;
          res_nxt.reject_reason = gts_pkg::REJ_NEED_STANDOFF;
        end
      end
      gts_pkg::CMD_CLOSE: begin
        if (!s_busy && (step_r != gts_pkg::S_AT_STANDOFF)) begin
          if ((step_r == gts_pkg::S_AT_HANDLE) || (step_r == gts_pkg::S_HOLDING)) begin
            step_nxt = gts_pkg::S_CLOSE_JAW;
          end
        end else begin
          res_nxt.accepted      = 1'b0;
          res_nxt.reject_reason = (step_r == gts_pkg::S_AT_STANDOFF) ?
                                  gts_pkg::REJ_EARLY_CLOSE : gts_pkg::REJ_WAIT;
        end
      end
      gts_pkg::CMD_OPEN, gts_pkg::CMD_HOME: begin
        if (!s_busy) begin
          if (w.command == gts_pkg::CMD_HOME) begin
            step_nxt = gts_pkg::S_MOVE_BASE;
          end else if (step_r == gts_pkg::S_HOLDING) begin
            step_nxt = gts_pkg::S_AT_HANDLE;
          end
        end else begin
          res_nxt.accepted      = 1'b0;
          res_nxt.reject_reason = gts_pkg::REJ_WAIT;
        end
      end
      gts_pkg::CMD_PLAN_RES: begin
        if (step_r == gts_pkg::S_PLANNING) begin
          if (w.plan_ok) begin
            step_nxt = gts_pkg::S_CHOSEN;
          end else begin
            step_nxt = (prior_r == gts_pkg::S_CHOSEN) ? gts_pkg::S_IDLE : prior_r;
          end
        end
      end
      default: begin
        res_nxt.accepted = 1'b0;
      end
    endcase
    if (step_nxt != step_r) begin
      age_nxt = '0;
    end
    res_nxt.step_code = step_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= gts_pkg::S_IDLE;
      prior_r     <= gts_pkg::S_IDLE;
      age_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        step_r  <= step_nxt;
        prior_r <= prior_nxt;
        age_r   <= age_nxt;
      end
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= res_nxt;
    end
  end

endmodule

[test/grasp_task_sequencer_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grasp_task_sequencer_checker
// Watches the config, input and result channels of the grasp task sequencer,
// keeps its own copy of step, prior step, step age and limits, predicts one
// result word per accepted input word and compares results in order.
// ----------------------------------------------------------------------------
module grasp_task_sequencer_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [3:0]  in_command,
  input  logic        in_arm_heard,
  input  logic        in_arm_moving,
  input  logic [2:0]  in_ctrl_state,
  input  logic [19:0] in_ctrl_age,
  input  logic        in_jaw_fresh,
  input  logic [15:0] in_jaw_width,
  input  logic        in_jaw_halted,
  input  logic [1:0]  in_grip,
  input  logic        in_carrying,
  input  logic        in_auto_run,
  input  logic        in_plan_ok,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [3:0]  out_step_code,
  input  logic [2:0]  out_action,
  input  logic        out_accepted,
  input  logic [2:0]  out_reject_reason,
  input  logic [2:0]  out_fault_reason,
  input  logic        out_backout_kept,
  output int          error_count,
  output int          results_due
);

  localparam int REPORT_MAX = 10;
  localparam logic [gts_pkg::AGE_W-1:0]   SILENCE_DEFAULT = 20'd2000;
  localparam logic [gts_pkg::AGE_W-1:0]   JAW_TMO_DEFAULT = 20'd3000;
  localparam logic [gts_pkg::WIDTH_W-1:0] JAW_TGT_DEFAULT = 16'd8000;
  localparam logic [gts_pkg::WIDTH_W-1:0] JAW_TOL_DEFAULT = 16'd200;

  typedef enum logic [1:0] {LEG_RUNNING, LEG_REACHED, LEG_BROKEN} leg_t;

  logic [gts_pkg::AGE_W-1:0]   silence_lim;
  logic [gts_pkg::AGE_W-1:0]   jaw_tmo;
  logic [gts_pkg::WIDTH_W-1:0] open_tgt;
  logic [gts_pkg::WIDTH_W-1:0] open_tol;
  logic [3:0]                  step_q;
  logic [3:0]                  prior_q;
  logic [gts_pkg::AGE_W-1:0]   age_q;
  gts_pkg::res_t               step_results_due[$];

  initial error_count = 0;

  function automatic logic busy_step(input logic [3:0] s);
    case (s)
      gts_pkg::S_PLANNING, gts_pkg::S_OPEN_JAW, gts_pkg::S_MOVE_STANDOFF,
      gts_pkg::S_MOVE_HANDLE, gts_pkg::S_CLOSE_JAW, gts_pkg::S_CHECK_GRASP,
      gts_pkg::S_MOVE_BASE: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // leg progress, judged on the step age after this tick
  function automatic leg_t watch_leg(output logic [2:0] flt);
    flt = gts_pkg::FLT_NONE;
    if (in_arm_heard && in_ctrl_age > silence_lim) begin
      flt = gts_pkg::FLT_SILENT;
      return LEG_BROKEN;
    end
    if (!in_arm_heard || !in_arm_moving) begin
      if (age_q > silence_lim) begin
        flt = gts_pkg::FLT_LEG_MISSED;
        return LEG_BROKEN;
      end
      return LEG_RUNNING;
    end
    case (in_ctrl_state)
      gts_pkg::CS_IDLE, gts_pkg::CS_STALLED, gts_pkg::CS_PILLOW,
      gts_pkg::CS_ABORTED: begin
        flt = gts_pkg::FLT_ARM_STOPPED;
        return LEG_BROKEN;
      end
      gts_pkg::CS_REACHED: return LEG_REACHED;
      default: return LEG_RUNNING;
    endcase
  endfunction

  task automatic predict_step_result(output gts_pkg::res_t r);
    logic [3:0]                  s;
    logic [3:0]                  ns;
    logic [2:0]                  act;
    logic [2:0]                  rej;
    logic [2:0]                  flt;
    logic                        acc;
    logic                        back;
    logic                        verdict;
    logic [gts_pkg::WIDTH_W-1:0] thr;
    leg_t                        leg;
    s    = step_q;
    ns   = s;
    act  = gts_pkg::ACT_NONE;
    rej  = gts_pkg::REJ_NONE;
    flt  = gts_pkg::FLT_NONE;
    acc  = 1'b1;
    back = 1'b0;
    case (in_command)
      gts_pkg::CMD_TICK: begin
        verdict = (in_grip == gts_pkg::GRIP_HELD) || (in_grip == gts_pkg::GRIP_EMPTY);
        thr = (open_tgt > open_tol) ? open_tgt - open_tol : '0;
        if (age_q != gts_pkg::AGE_MAX) age_q = age_q + 1'b1;
        case (s)
          gts_pkg::S_OPEN_JAW: begin
            if (in_jaw_fresh && in_jaw_width >= thr) begin
              ns  = gts_pkg::S_MOVE_STANDOFF;
              act = gts_pkg::ACT_STANDOFF;
            end else if (age_q > jaw_tmo) begin
              ns  = gts_pkg::S_FAILED;
              flt = gts_pkg::FLT_JAW_OPEN;
            end
          end
          gts_pkg::S_MOVE_STANDOFF, gts_pkg::S_MOVE_HANDLE, gts_pkg::S_MOVE_BASE: begin
            leg = watch_leg(flt);
            if (leg == LEG_BROKEN) begin
              ns   = gts_pkg::S_FAILED;
              back = (s != gts_pkg::S_MOVE_BASE);
            end else if (leg == LEG_REACHED) begin
              case (s)
                gts_pkg::S_MOVE_STANDOFF: ns = gts_pkg::S_AT_STANDOFF;
                gts_pkg::S_MOVE_HANDLE:   ns = gts_pkg::S_AT_HANDLE;
                default: ns = in_carrying ? gts_pkg::S_SUCCESS : gts_pkg::S_IDLE;
              endcase
            end
          end
          gts_pkg::S_AT_STANDOFF: begin
            if (in_auto_run) begin
              ns  = gts_pkg::S_MOVE_HANDLE;
              act = gts_pkg::ACT_HANDLE;
            end
          end
          gts_pkg::S_AT_HANDLE: begin
            if (in_auto_run) begin
              ns  = gts_pkg::S_CLOSE_JAW;
              act = gts_pkg::ACT_CLOSE;
            end
          end
          gts_pkg::S_CLOSE_JAW: begin
            if (verdict || in_jaw_halted) begin
              ns = gts_pkg::S_CHECK_GRASP;
            end else if (age_q > jaw_tmo) begin
              ns  = gts_pkg::S_HOLDING;
              flt = gts_pkg::FLT_JAW_SETTLE;
            end
          end
          gts_pkg::S_CHECK_GRASP: begin
            if (verdict) begin
              ns = gts_pkg::S_HOLDING;
            end else if (age_q > jaw_tmo) begin
              ns  = gts_pkg::S_HOLDING;
              flt = gts_pkg::FLT_GRIP;
            end
          end
          gts_pkg::S_HOLDING: begin
            if (in_auto_run) begin
              ns  = gts_pkg::S_MOVE_BASE;
              act = gts_pkg::ACT_HOME;
            end
          end
          default: ;
        endcase
      end
      gts_pkg::CMD_STOP: ns = gts_pkg::S_E_STOP;
      gts_pkg::CMD_PLAN: begin
        if (s == gts_pkg::S_IDLE || s == gts_pkg::S_CHOSEN || s == gts_pkg::S_SUCCESS ||
            s == gts_pkg::S_FAILED || s == gts_pkg::S_E_STOP) begin
          prior_q = s;
          ns = gts_pkg::S_PLANNING;
        end else begin
          acc = 1'b0;
          rej = gts_pkg::REJ_PLAN_BUSY;
        end
      end
      gts_pkg::CMD_START: begin
        if (s == gts_pkg::S_CHOSEN) begin
          ns = gts_pkg::S_OPEN_JAW;
        end else begin
          acc = 1'b0;
          rej = (busy_step(s) || s == gts_pkg::S_AT_STANDOFF ||
                 s == gts_pkg::S_AT_HANDLE || s == gts_pkg::S_HOLDING) ?
                gts_pkg::REJ_NEED_PLAN : gts_pkg::REJ_NO_PLAN;
        end
      end
      gts_pkg::CMD_ADVANCE: begin
        if (s == gts_pkg::S_AT_STANDOFF) begin
          ns = gts_pkg::S_MOVE_HANDLE;
        end else begin
          acc = 1'b0;
          rej = gts_pkg::REJ_NEED_STANDOFF;
        end
      end
      gts_pkg::CMD_CLOSE: begin
        if (busy_step(s) || s == gts_pkg::S_AT_STANDOFF) begin
          acc = 1'b0;
          rej = (s == gts_pkg::S_AT_STANDOFF) ? gts_pkg::REJ_EARLY_CLOSE : gts_pkg::REJ_WAIT;
        end else if (s == gts_pkg::S_AT_HANDLE || s == gts_pkg::S_HOLDING) begin
          ns = gts_pkg::S_CLOSE_JAW;
        end
      end
      gts_pkg::CMD_OPEN, gts_pkg::CMD_HOME: begin
        if (busy_step(s)) begin
          acc = 1'b0;
          rej = gts_pkg::REJ_WAIT;
        end else if (in_command == gts_pkg::CMD_HOME) begin
          ns = gts_pkg::S_MOVE_BASE;
        end else if (s == gts_pkg::S_HOLDING) begin
          ns = gts_pkg::S_AT_HANDLE;
        end
      end
      gts_pkg::CMD_PLAN_RES: begin
        if (s == gts_pkg::S_PLANNING) begin
          if (in_plan_ok) ns = gts_pkg::S_CHOSEN;
          else ns = (prior_q == gts_pkg::S_CHOSEN) ? gts_pkg::S_IDLE : prior_q;
        end
      end
      default: acc = 1'b0;
    endcase
    if (ns != s) age_q = '0;
    step_q = ns;
    r.step_code     = ns;
    r.action        = act;
    r.accepted      = acc;
    r.reject_reason = rej;
    r.fault_reason  = flt;
    r.backout_kept  = back;
  endtask

  always @(posedge clk) begin
    gts_pkg::res_t want;
    gts_pkg::res_t got;
    if (!rst_n) begin
      silence_lim = SILENCE_DEFAULT;
      jaw_tmo     = JAW_TMO_DEFAULT;
      open_tgt    = JAW_TGT_DEFAULT;
      open_tol    = JAW_TOL_DEFAULT;
      step_q      = gts_pkg::S_IDLE;
      prior_q     = gts_pkg::S_IDLE;
      age_q       = '0;
      step_results_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          gts_pkg::REG_SILENCE: silence_lim = cfg_data;
          gts_pkg::REG_JAW_TMO: jaw_tmo     = cfg_data;
          gts_pkg::REG_JAW_TGT: open_tgt    = cfg_data[gts_pkg::WIDTH_W-1:0];
          gts_pkg::REG_JAW_TOL: open_tol    = cfg_data[gts_pkg::WIDTH_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got.step_code     = out_step_code;
        got.action        = out_action;
        got.accepted      = out_accepted;
        got.reject_reason = out_reject_reason;
        got.fault_reason  = out_fault_reason;
        got.backout_kept  = out_backout_kept;
        if (step_results_due.size() == 0) begin
          if (error_count < REPORT_MAX)
            $display("%0t: result word with nothing pending: step %0d action %0d", $time,
                     got.step_code, got.action);
          error_count = error_count + 1;
        end else begin
          want = step_results_due.pop_front();
          if (want != got) begin
            if (error_count < REPORT_MAX) begin
              $display("%0t: result mismatch", $time);
              $display("  expected step %0d action %0d acc %0d rej %0d fault %0d back %0d",
                       want.step_code, want.action, want.accepted, want.reject_reason,
                       want.fault_reason, want.backout_kept);
              $display("  actual   step %0d action %0d acc %0d rej %0d fault %0d back %0d",
                       got.step_code, got.action, got.accepted, got.reject_reason,
                       got.fault_reason, got.backout_kept);
            end
            error_count = error_count + 1;
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_step_result(want);
        step_results_due.push_back(want);
      end
    end
    results_due <= step_results_due.size();
  end

endmodule

[test/grasp_task_sequencer_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grasp_task_sequencer_tb
// Drives the grasp task sequencer with a directed walk through the steps and
// then phases of randomized pick sequences under several limit settings,
// with random input gaps and result stalls; the checker does the scoring.
// ----------------------------------------------------------------------------
module grasp_task_sequencer_tb;

  localparam int PHASES          = 6;
  localparam int WORDS_PER_PHASE = 215;
  localparam int STALL_LIMIT     = 1000;

  localparam logic [3:0] CMD_LAST_CODE = 4'd15;
  localparam logic [2:0] CS_MOVING     = 3'd1;
  localparam logic [2:0] CS_UNKNOWN    = 3'd7;
  localparam logic [1:0] GRIP_UNKNOWN  = 2'd0;
  localparam logic [1:0] GRIP_ODD      = 2'd3;

  typedef struct packed {
    logic        seen;
    logic        busy;
    logic [2:0]  cstate;
    logic [19:0] cage;
    logic        fresh;
    logic [15:0] width;
    logic        still;
    logic [1:0]  grip;
    logic        carry;
    logic        autos;
    logic        plan_ok;
  } status_t;

  logic        clk              = 1'b0;
  logic        rst_n            = 1'b0;
  logic        cfg_valid        = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index        = '0;
  logic [19:0] cfg_data         = '0;
  logic        in_valid         = 1'b0;
  logic        in_ready;
  logic [3:0]  in_command       = '0;
  logic        in_arm_heard     = 1'b0;
  logic        in_arm_moving    = 1'b0;
  logic [2:0]  in_ctrl_state    = '0;
  logic [19:0] in_ctrl_age      = '0;
  logic        in_jaw_fresh     = 1'b0;
  logic [15:0] in_jaw_width     = '0;
  logic        in_jaw_halted    = 1'b0;
  logic [1:0]  in_grip          = '0;
  logic        in_carrying      = 1'b0;
  logic        in_auto_run      = 1'b0;
  logic        in_plan_ok       = 1'b0;
  logic        out_valid;
  logic        out_ready        = 1'b0;
  logic [3:0]  out_step_code;
  logic [2:0]  out_action;
  logic        out_accepted;
  logic [2:0]  out_reject_reason;
  logic [2:0]  out_fault_reason;
  logic        out_backout_kept;
  int          error_count;
  int          results_due;

  bit quiet       = 1'b0;
  int idle_pct    = 12;
  int stall_left  = 0;
  int idle_cycles = 0;
  int words_sent  = 0;
  int cur_sil     = 2000;
  int cur_tmo     = 3000;
  int cur_tgt     = 8000;
  int cur_tol     = 200;

  grasp_task_sequencer i_dut (.*);

  grasp_task_sequencer_checker i_checker (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (quiet || idle_pct == 0) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      stall_left <= $urandom_range(0, 10);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("FAIL grasp_task_sequencer");
    $finish;
  end

  function automatic int clamp(input int v, input int hi);
    return (v < 0) ? 0 : (v > hi) ? hi : v;
  endfunction

  function automatic status_t calm_status();
    status_t st;
    st = '0;
    st.seen   = 1'b1;
    st.busy   = 1'b1;
    st.cstate = CS_MOVING;
    st.grip   = GRIP_UNKNOWN;
    return st;
  endfunction

  function automatic status_t roll_status();
    status_t st;
    int      thr;
    int      r;
    st.seen = ($urandom_range(0, 9) != 0);
    st.busy = ($urandom_range(0, 19) > 2);
    r = $urandom_range(0, 99);
    if (r < 45) st.cstate = gts_pkg::CS_REACHED;
    else if (r < 80) st.cstate = CS_MOVING;
    else st.cstate = 3'($urandom_range(0, 7));
    r = $urandom_range(0, 99);
    if (r < 70) st.cage = 20'($urandom_range(0, 4));
    else if (r < 85) st.cage = 20'(clamp(cur_sil + int'($urandom_range(0, 2)) - 1,
                                         int'(gts_pkg::AGE_MAX)));
    else st.cage = 20'($urandom);
    st.fresh = ($urandom_range(0, 9) < 7);
    thr = (cur_tgt > cur_tol) ? cur_tgt - cur_tol : 0;
    r = $urandom_range(0, 99);
    if (r < 40) st.width = 16'(clamp(thr + int'($urandom_range(0, 4)) - 2, 16'hFFFF));
    else if (r < 70) st.width = 16'($urandom);
    else if (r < 85) st.width = '0;
    else st.width = 16'hFFFF;
    st.still   = ($urandom_range(0, 9) < 3);
    st.grip    = ($urandom_range(0, 1) == 0) ? GRIP_UNKNOWN : 2'($urandom_range(0, 3));
    st.carry   = 1'($urandom_range(0, 1));
    st.autos   = ($urandom_range(0, 9) < 6);
    st.plan_ok = ($urandom_range(0, 9) < 8);
    return st;
  endfunction

  function automatic status_t wild_status();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return status_t'(bits[$bits(status_t)-1:0]);
  endfunction

  function automatic logic [3:0] pick_command();
    int r;
    r = $urandom_range(0, 99);
    if (r < 72) return gts_pkg::CMD_TICK;
    if (r < 74) return gts_pkg::CMD_STOP;
    if (r < 77) return gts_pkg::CMD_PLAN;
    if (r < 80) return gts_pkg::CMD_START;
    if (r < 85) return gts_pkg::CMD_ADVANCE;
    if (r < 90) return gts_pkg::CMD_CLOSE;
    if (r < 94) return gts_pkg::CMD_OPEN;
    if (r < 97) return gts_pkg::CMD_HOME;
    if (r < 99) return gts_pkg::CMD_PLAN_RES;
    return 4'($urandom_range(9, 15));
  endfunction

  task automatic put_word(input logic [3:0] cmd, input status_t st);
    if (!quiet && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_command       <= cmd;
    in_arm_heard     <= st.seen;
    in_arm_moving    <= st.busy;
    in_ctrl_state    <= st.cstate;
    in_ctrl_age      <= st.cage;
    in_jaw_fresh     <= st.fresh;
    in_jaw_width     <= st.width;
    in_jaw_halted    <= st.still;
    in_grip          <= st.grip;
    in_carrying      <= st.carry;
    in_auto_run      <= st.autos;
    in_plan_ok       <= st.plan_ok;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic put_reg(input logic [1:0] idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 20'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic write_config(input int sil, input int tmo, input int tgt, input int tol);
    cur_sil = sil;
    cur_tmo = tmo;
    cur_tgt = tgt;
    cur_tol = tol;
    put_reg(gts_pkg::REG_SILENCE, sil);
    put_reg(gts_pkg::REG_JAW_TMO, tmo);
    put_reg(gts_pkg::REG_JAW_TGT, tgt);
    put_reg(gts_pkg::REG_JAW_TOL, tol);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (4) @(posedge clk);
  endtask

  // walk through the steps with silence and jaw limits of one tick
  task automatic run_directed();
    status_t st;
    st = calm_status();
    put_word(gts_pkg::CMD_TICK, st);
    put_word(gts_pkg::CMD_ADVANCE, st);
    put_word(gts_pkg::CMD_START, st);
    put_word(gts_pkg::CMD_PLAN, st);
    put_word(gts_pkg::CMD_PLAN, st);
    put_word(gts_pkg::CMD_START, st);
    put_word(gts_pkg::CMD_PLAN_RES, st);
    put_word(gts_pkg::CMD_PLAN, st);
    st.plan_ok = 1'b1;
    put_word(gts_pkg::CMD_PLAN_RES, st);
    put_word(gts_pkg::CMD_START, st);
    st.fresh = 1'b1;
    st.width = 16'd69;
    put_word(gts_pkg::CMD_TICK, st);
    put_word(gts_pkg::CMD_TICK, st);
    st.plan_ok = 1'b0;
    put_word(gts_pkg::CMD_PLAN, st);
    put_word(gts_pkg::CMD_PLAN_RES, st);
    put_word(gts_pkg::CMD_PLAN, st);
    st.plan_ok = 1'b1;
    put_word(gts_pkg::CMD_PLAN_RES, st);
    put_word(gts_pkg::CMD_START, st);
    st.width = 16'd70;
    put_word(gts_pkg::CMD_TICK, st);
    st.cstate = CS_UNKNOWN;
    put_word(gts_pkg::CMD_TICK, st);
    st.cstate = gts_pkg::CS_REACHED;
    put_word(gts_pkg::CMD_TICK, st);
    put_word(gts_pkg::CMD_CLOSE, st);
    put_word(gts_pkg::CMD_ADVANCE, st);
    st.cstate = gts_pkg::CS_STALLED;
    put_word(gts_pkg::CMD_TICK, st);
    put_word(gts_pkg::CMD_STOP, st);
    put_word(CMD_LAST_CODE, st);
    put_word(gts_pkg::CMD_PLAN_RES, st);
    put_word(gts_pkg::CMD_HOME, st);
    st.seen = 1'b0;
    st.grip = GRIP_ODD;
    put_word(gts_pkg::CMD_TICK, st);
    put_word(gts_pkg::CMD_TICK, st);
  endtask

  task automatic run_pick();
    if ($urandom_range(0, 4) == 0) begin
      put_word(gts_pkg::CMD_HOME, roll_status());
    end else begin
      put_word(gts_pkg::CMD_PLAN, roll_status());
      repeat ($urandom_range(0, 2)) put_word(gts_pkg::CMD_TICK, roll_status());
      put_word(gts_pkg::CMD_PLAN_RES, roll_status());
      put_word(gts_pkg::CMD_START, roll_status());
    end
    repeat ($urandom_range(8, 40)) put_word(pick_command(), roll_status());
  endtask

  initial begin
    int p;
    int goal;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_config(1, 1, 100, 30);
    run_directed();
    for (p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: write_config(0, 0, 0, 0);
        1: write_config(int'(gts_pkg::AGE_MAX), int'(gts_pkg::AGE_MAX), 16'hFFFF, 16'hFFFF);
        2: write_config(5, 6, 50, 200);
        4: write_config(2000, 3000, 8000, 200);
        default: write_config($urandom_range(0, 12), $urandom_range(0, 12),
                              $urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF));
      endcase
      idle_pct <= (p == 2) ? 0 : (p == 3) ? 30 : 12;
      quiet    <= (p == PHASES - 1);
      @(posedge clk);
      goal = words_sent + WORDS_PER_PHASE;
      while (words_sent < goal) begin
        if ($urandom_range(0, 99) < 12)
          put_word(4'($urandom_range(0, 15)), wild_status());
        else
          run_pick();
      end
    end
    drain();
    repeat (8) @(posedge clk);
    if (error_count == 0 && results_due == 0)
      $display("PASS grasp_task_sequencer");
    else
      $display("FAIL grasp_task_sequencer");
    $finish;
  end

endmodule
